[src/ffha_pkg.sv]
package ffha_pkg;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_FIT    = 2'd1;
   localparam logic [1:0] STATUS_TABLE_FULL = 2'd2;

   localparam logic ACTION_ALLOC = 1'b0;
   localparam logic ACTION_FREE  = 1'b1;

   localparam logic CSR_HEAP_BASE = 1'b0;
   localparam logic CSR_HEAP_END  = 1'b1;

   localparam logic [15:0] EVEN_MASK = 16'hfffe;

   typedef struct packed {
      logic [15:0] start;
      logic [15:0] length;
   } ffha_entry_type;

endpackage

[src/first_fit_heap_allocator.sv]
// First-fit heap allocator over an address-ordered table of free extents kept in a
// FREE_SLOTS-entry memory with one write port and one registered read port. Each request
// is handled by a small sequencer that reads one table entry at a time, in a read state
// and a check state: an allocate scans until the first extent that fits, a free scans
// to its insertion point and then shifts the tail of the table one entry at a time on a
// merge of both neighbors or an insert. The result is registered when the scan and
// shift through the single read port are done; a result still waiting in the output
// register holds the sequencer in its last state. The block takes no request while one
// is in work. After reset and after each write of heap_base or heap_end the first table
// entry is rewritten before the next request is taken.
// A free must give the granted size returned by its allocate.
module first_fit_heap_allocator #(
   parameter int FREE_SLOTS   = 16,
   parameter int BLOCK_HEADER = 4,
   parameter int HEAP_HEADER  = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // action[0], request_bytes[16:1], block_address[32:17], block_size[48:33]
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], granted_address[17:2], granted_size[33:18],
   // blocks_in_use[49:34], bytes_in_use[65:50]
   output logic [71:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata
);
   import ffha_pkg::*;

   localparam int IW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
   localparam int CW = $clog2(FREE_SLOTS + 1);
   localparam logic [15:0] BH16 = 16'(BLOCK_HEADER);
   localparam logic [15:0] HH16 = 16'(HEAP_HEADER);
   localparam logic [16:0] NEED_PAD = 17'(2 * BLOCK_HEADER);
   localparam logic [CW-1:0] SLOTS_C = CW'(FREE_SLOTS);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_ARD  = 4'd1;
   localparam logic [3:0] S_ACK  = 4'd2;
   localparam logic [3:0] S_FRD  = 4'd3;
   localparam logic [3:0] S_FCK  = 4'd4;
   localparam logic [3:0] S_DEC  = 4'd5;
   localparam logic [3:0] S_SRD  = 4'd6;
   localparam logic [3:0] S_SWR  = 4'd7;
   localparam logic [3:0] S_INS  = 4'd8;
   localparam logic [3:0] S_FIN  = 4'd9;

   ffha_entry_type mem [FREE_SLOTS];
   ffha_entry_type rd_data_ff;

   logic [3:0]     state_ff, state_in;
   logic           pending_ff, pending_in;
   logic [15:0]    base_ff, base_in, end_ff, end_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [15:0]    blocks_ff, blocks_in, bytes_ff, bytes_in;
   logic [CW-1:0]  k_ff, k_in, sh_ff, sh_in;
   logic           op_ff, op_in, remove_ff, remove_in;
   logic [15:0]    req_ff, req_in, ptr_ff, ptr_in, size_ff, size_in;
   ffha_entry_type prev_ff, prev_in, next_ff, next_in;
   logic           has_prev_ff, has_prev_in, has_next_ff, has_next_in;
   logic [1:0]     res_status_ff, res_status_in;
   logic [15:0]    res_addr_ff, res_addr_in, res_size_ff, res_size_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [71:0]    rsp_data_ff, rsp_data_in;

   logic           wr_en;
   logic [IW-1:0]  wr_addr, rd_addr;
   ffha_entry_type wr_data;

   logic [16:0]    need;
   logic [15:0]    hdr, blk_end;
   logic           prev_adj, next_adj;

   assign req_tready = (state_ff == S_IDLE) && !pending_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign need     = {1'b0, req_ff} + NEED_PAD;
   assign hdr      = ptr_ff - BH16;
   assign blk_end  = hdr + size_ff;
   assign prev_adj = has_prev_ff && ((prev_ff.start + prev_ff.length) == hdr);
   assign next_adj = has_next_ff && (blk_end == next_ff.start);

   always_comb begin
      state_in      = state_ff;
      pending_in    = pending_ff;
      base_in       = base_ff;
      end_in        = end_ff;
      count_in      = count_ff;
      blocks_in     = blocks_ff;
      bytes_in      = bytes_ff;
      k_in          = k_ff;
      sh_in         = sh_ff;
      op_in         = op_ff;
      remove_in     = remove_ff;
      req_in        = req_ff;
      ptr_in        = ptr_ff;
      size_in       = size_ff;
      prev_in       = prev_ff;
      next_in       = next_ff;
      has_prev_in   = has_prev_ff;
      has_next_in   = has_next_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      res_size_in   = res_size_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = k_ff[IW-1:0];
      wr_data       = '0;
      rd_addr       = k_ff[IW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (pending_ff) begin
               wr_en        = 1'b1;
               wr_addr      = '0;
               wr_data.start  = base_ff + HH16;
               wr_data.length = end_ff - base_ff - HH16;
               pending_in   = 1'b0;
            end else if (req_tvalid) begin
               op_in         = req_tdata[0];
               req_in        = (req_tdata[16:1] + 16'd1) & EVEN_MASK;
               ptr_in        = req_tdata[32:17];
               size_in       = req_tdata[48:33];
               k_in          = '0;
               has_prev_in   = 1'b0;
               has_next_in   = 1'b0;
               res_status_in = STATUS_OK;
               res_addr_in   = '0;
               res_size_in   = '0;
               if (count_ff == '0) begin
                  res_status_in = (req_tdata[0] == ACTION_ALLOC) ? STATUS_NO_FIT : STATUS_OK;
                  state_in = (req_tdata[0] == ACTION_ALLOC) ? S_FIN : S_DEC;
               end else begin
                  state_in = (req_tdata[0] == ACTION_ALLOC) ? S_ARD : S_FRD;
               end
            end
         end
         S_ARD: state_in = S_ACK;
         S_ACK: begin
            if ({1'b0, rd_data_ff.length} > need) begin
               wr_en          = 1'b1;
               wr_data.start  = rd_data_ff.start + req_ff + BH16;
               wr_data.length = rd_data_ff.length - (req_ff + BH16);
               res_addr_in    = rd_data_ff.start + BH16;
               res_size_in    = req_ff + BH16;
               state_in       = S_FIN;
            end else if ((k_ff + 1'b1) < count_ff) begin
               k_in     = k_ff + 1'b1;
               state_in = S_ARD;
            end else begin
               res_status_in = STATUS_NO_FIT;
               state_in      = S_FIN;
            end
         end
         S_FRD: state_in = S_FCK;
         S_FCK: begin
            if (rd_data_ff.start < ptr_ff) begin
               prev_in     = rd_data_ff;
               has_prev_in = 1'b1;
               k_in        = k_ff + 1'b1;
               state_in    = ((k_ff + 1'b1) < count_ff) ? S_FRD : S_DEC;
            end else begin
               next_in     = rd_data_ff;
               has_next_in = 1'b1;
               state_in    = S_DEC;
            end
         end
         S_DEC: begin
            if (prev_adj) begin
               wr_en         = 1'b1;
               wr_addr       = IW'(k_ff - 1'b1);
               wr_data.start = prev_ff.start;
               if (next_adj) begin
                  // both neighbors touch: grow the lower one, drop the upper one
                  wr_data.length = prev_ff.length + size_ff + next_ff.length;
                  remove_in = 1'b1;
                  sh_in     = k_ff;
                  if ((k_ff + 1'b1) < count_ff) begin
                     state_in = S_SRD;
                  end else begin
                     count_in = count_ff - 1'b1;
                     state_in = S_FIN;
                  end
               end else begin
                  wr_data.length = prev_ff.length + size_ff;
                  state_in = S_FIN;
               end
            end else if (next_adj) begin
               wr_en          = 1'b1;
               wr_data.start  = hdr;
               wr_data.length = next_ff.length + size_ff;
               state_in       = S_FIN;
            end else if (count_ff >= SLOTS_C) begin
               res_status_in = STATUS_TABLE_FULL;
               state_in      = S_FIN;
            end else begin
               remove_in = 1'b0;
               sh_in     = count_ff;
               state_in  = (count_ff > k_ff) ? S_SRD : S_INS;
            end
         end
         S_SRD: begin
            rd_addr  = remove_ff ? IW'(sh_ff + 1'b1) : IW'(sh_ff - 1'b1);
            state_in = S_SWR;
         end
         S_SWR: begin
            wr_en   = 1'b1;
            wr_addr = sh_ff[IW-1:0];
            wr_data = rd_data_ff;
            if (remove_ff) begin
               sh_in = sh_ff + 1'b1;
               if (({1'b0, sh_ff} + (CW+1)'(2)) < {1'b0, count_ff}) begin
                  state_in = S_SRD;
               end else begin
                  count_in = count_ff - 1'b1;
                  state_in = S_FIN;
               end
            end else begin
               sh_in    = sh_ff - 1'b1;
               state_in = ((sh_ff - 1'b1) > k_ff) ? S_SRD : S_INS;
            end
         end
         S_INS: begin
            wr_en          = 1'b1;
            wr_data.start  = hdr;
            wr_data.length = size_ff;
            count_in       = count_ff + 1'b1;
            state_in       = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               if (res_status_ff == STATUS_OK) begin
                  if (op_ff == ACTION_ALLOC) begin
                     blocks_in = blocks_ff + 16'd1;
                     bytes_in  = bytes_ff + res_size_ff;
                  end else begin
                     blocks_in = blocks_ff - 16'd1;
                     bytes_in  = bytes_ff - size_ff;
                  end
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0, bytes_in, blocks_in, res_size_ff, res_addr_ff,
                               res_status_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // window writes must arrive only while idle; the block itself does not enforce this
      if (csr_we) begin
         if (csr_addr == CSR_HEAP_BASE) base_in = csr_wdata;
         if (csr_addr == CSR_HEAP_END)  end_in  = csr_wdata;
         pending_in = 1'b1;
         count_in   = CW'(1);
         blocks_in  = '0;
         bytes_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pending_ff   <= 1'b1;
         base_ff      <= 16'd0;
         end_ff       <= 16'd32768;
         count_ff     <= CW'(1);
         blocks_ff    <= '0;
         bytes_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         base_ff      <= base_in;
         end_ff       <= end_in;
         count_ff     <= count_in;
         blocks_ff    <= blocks_in;
         bytes_ff     <= bytes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff          <= k_in;
      sh_ff         <= sh_in;
      op_ff         <= op_in;
      remove_ff     <= remove_in;
      req_ff        <= req_in;
      ptr_ff        <= ptr_in;
      size_ff       <= size_in;
      prev_ff       <= prev_in;
      next_ff       <= next_in;
      has_prev_ff   <= has_prev_in;
      has_next_ff   <= has_next_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      res_size_ff   <= res_size_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule
